// File: hdl/plk_pkg.sv
// Package for the peak limiter with taper.
// Holds the sample format, arithmetic widths and register map used by the divider, top level and bench.
// Depends on nothing.
package plk_pkg;

	localparam int SAMPLE_W = 24;
	localparam int FRAC_W = 20;
	localparam logic signed [SAMPLE_W-1:0] Q_ONE = 24'sd1048576;
	localparam logic signed [SAMPLE_W-1:0] Q_MINUS_ONE = -24'sd1048576;

	localparam int TAPER_W = 5;
	localparam int K_W = 6;
	localparam int NUM_W = 29;
	localparam int DEN_W = 29;
	localparam int PROD_W = 53;
	localparam int DIV_W = 56;
	localparam int QUO_W = 24;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_N_STEPS = 1'b0;
	localparam logic [TAPER_W-1:0] N_STEPS_RESET = 5'd4;

endpackage

// File: hdl/plk_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds its value until the next read. Depends on nothing.
module plk_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/plk_div.sv
// Restoring divider that produces one quotient bit per cycle.
// The quotient must fit in QUO_W bits. Depends on plk_pkg.
module plk_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [plk_pkg::DIV_W-1:0]       dividend,
	input  logic [plk_pkg::DIV_W-1:0]       divisor,
	output logic                            done,
	output logic [plk_pkg::QUO_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(plk_pkg::QUO_W + 1);

	logic [plk_pkg::DIV_W-1:0] rem_q;
	logic [plk_pkg::DIV_W-1:0] dvs_q;
	logic [plk_pkg::QUO_W-1:0] quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic                      ge;

	assign ge = (rem_q >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(plk_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor << (plk_pkg::QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[plk_pkg::QUO_W-2:0], ge};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// File: hdl/peak_limiter_with_taper.sv
// Top level of the peak limiter with taper: window memory, sequencer and ports.
// Depends on plk_pkg, plk_ram and plk_div.
//
//  channel   direction  handshake            payload
//  input     in         in_valid/in_ready    sample, last
//  output    out        out_valid/out_ready  sample_out, end_of_stream
//  config    in         APB psel/penable     n_steps at address 0
//
// One transaction is taken at a time; a new input is accepted only when the sequencer is idle.
// Each input is stored, then every sample ready for examination is read and evaluated, then every sample ready
// to leave is read and loaded; each tapered neighbor of a peak is read, multiplied and divided by the serial divider.
// The window lives in one RAM used as a circular buffer; reset clears only the control state.
// A stalled output holds the sequencer in its emit step until the transaction completes.
module peak_limiter_with_taper #(
	parameter int MAX_STEPS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [plk_pkg::SAMPLE_W-1:0]     sample,
	input  logic                                    last,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [plk_pkg::SAMPLE_W-1:0]     sample_out,
	output logic                                    end_of_stream,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [plk_pkg::CFG_ADDR_W-1:0]          paddr,
	input  logic [plk_pkg::CFG_DATA_W-1:0]          pwdata,
	output logic [plk_pkg::CFG_DATA_W-1:0]          prdata,
	output logic                                    pready
);

	localparam int WIN = 2 * MAX_STEPS + 1;
	localparam int AW = $clog2(WIN);
	localparam int CW = $clog2(WIN + 1);
	localparam int SW = plk_pkg::SAMPLE_W;

	typedef enum logic [3:0] {
		S_IDLE, S_EXAM, S_EVAL, S_NBSEL, S_NBMUL, S_DIV, S_DWAIT, S_EMIT, S_ELOAD
	} state_t;

	state_t                          state_q;
	logic [plk_pkg::TAPER_W-1:0]     n_steps_q;
	logic [plk_pkg::TAPER_W-1:0]     taper_q;
	logic                            in_stream_q;
	logic                            last_q;
	logic [CW-1:0]                   fill_q;
	logic [CW-1:0]                   done_q;
	logic [AW-1:0]                   head_q;
	logic [CW-1:0]                   p_q;
	logic [AW-1:0]                   p_addr_q;
	logic [plk_pkg::K_W-1:0]         k_q;
	logic                            side_q;
	logic [SW-1:0]                   mag_q;
	logic [plk_pkg::DEN_W-1:0]       den_q;
	logic [plk_pkg::NUM_W-1:0]       num_q;
	logic [plk_pkg::PROD_W-1:0]      prod_q;
	logic                            neg_q;
	logic [AW-1:0]                   nb_addr_q;
	logic                            out_valid_q;
	logic signed [SW-1:0]            out_data_q;
	logic                            out_eos_q;

	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [SW-1:0]                   ram_wdata;
	logic                            ram_re;
	logic [AW-1:0]                   ram_raddr;
	logic [SW-1:0]                   ram_rdata;

	logic                            div_start;
	logic                            div_done;
	logic [plk_pkg::DIV_W-1:0]       div_dividend;
	logic [plk_pkg::DIV_W-1:0]       div_divisor;
	logic [plk_pkg::QUO_W-1:0]       div_quo;

	logic                            cfg_wr;
	logic                            in_acc;
	logic                            exam_go;
	logic                            emit_go;
	logic                            right_ok;
	logic                            left_ok;
	logic                            nb_avail;
	logic                            k_over;
	logic                            out_free;
	logic [plk_pkg::K_W-1:0]         n1;
	logic signed [SW-1:0]            rd_s;
	logic [SW-1:0]                   rd_mag;
	logic                            peak_hi;
	logic                            peak_lo;
	logic [CW:0]                     right_off;
	logic [CW:0]                     left_off;
	logic [SW-1:0]                   scaled;

	function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
	                                            input logic [CW:0] off);
		logic [CW+1:0] sum;
		sum = (CW+2)'(base) + (CW+2)'(off);
		if (sum >= (CW+2)'(WIN)) begin
			sum = sum - (CW+2)'(WIN);
		end
		return sum[AW-1:0];
	endfunction

	assign cfg_wr = psel && penable && pwrite && (paddr[2] == plk_pkg::REG_N_STEPS);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == plk_pkg::REG_N_STEPS) ?
		plk_pkg::CFG_DATA_W'(n_steps_q) : '0;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign n1 = plk_pkg::K_W'(taper_q) + 1'b1;
	assign exam_go = last_q ? (done_q < fill_q) :
		((CW+1)'(done_q) + (CW+1)'(taper_q) < (CW+1)'(fill_q));
	assign emit_go = (fill_q != '0) && (last_q || ((CW+1)'(done_q) > (CW+1)'(taper_q)));
	assign right_off = (CW+1)'(p_q) + (CW+1)'(k_q);
	assign left_off = (CW+1)'(p_q) - (CW+1)'(k_q);
	assign right_ok = right_off < (CW+1)'(fill_q);
	assign left_ok = (CW+1)'(k_q) <= (CW+1)'(p_q);
	assign nb_avail = side_q ? left_ok : right_ok;
	assign k_over = k_q > plk_pkg::K_W'(taper_q);

	assign rd_s = $signed(ram_rdata);
	assign rd_mag = rd_s[SW-1] ? SW'(-rd_s) : SW'(rd_s);
	assign peak_hi = rd_s > plk_pkg::Q_ONE;
	assign peak_lo = rd_s < plk_pkg::Q_MINUS_ONE;
	assign scaled = neg_q ? SW'(-div_quo) : SW'(div_quo);

	assign div_start = (state_q == S_DIV);
	assign div_dividend = plk_pkg::DIV_W'({prod_q, 1'b0}) + plk_pkg::DIV_W'(den_q);
	assign div_divisor = plk_pkg::DIV_W'({den_q, 1'b0});

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_we = in_acc;
				ram_waddr = wrap_addr(head_q, (CW+1)'(fill_q));
				ram_wdata = sample;
			end
			S_EXAM: begin
				ram_re = exam_go;
				ram_raddr = wrap_addr(head_q, (CW+1)'(done_q));
			end
			S_EVAL: begin
				ram_we = peak_hi || peak_lo;
				ram_waddr = p_addr_q;
				ram_wdata = peak_hi ? plk_pkg::Q_ONE : plk_pkg::Q_MINUS_ONE;
			end
			S_NBSEL: begin
				ram_re = !k_over && nb_avail;
				ram_raddr = wrap_addr(head_q, side_q ? left_off : right_off);
			end
			S_DWAIT: begin
				ram_we = div_done;
				ram_waddr = nb_addr_q;
				ram_wdata = scaled;
			end
			S_EMIT: begin
				ram_re = emit_go;
				ram_raddr = head_q;
			end
			S_NBMUL, S_DIV, S_ELOAD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_steps_q <= plk_pkg::N_STEPS_RESET;
			taper_q <= plk_pkg::N_STEPS_RESET;
			in_stream_q <= 1'b0;
			last_q <= 1'b0;
			fill_q <= '0;
			done_q <= '0;
			head_q <= '0;
			p_q <= '0;
			p_addr_q <= '0;
			k_q <= '0;
			side_q <= 1'b0;
			mag_q <= '0;
			den_q <= '0;
			num_q <= '0;
			prod_q <= '0;
			neg_q <= 1'b0;
			nb_addr_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			out_eos_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				n_steps_q <= pwdata[plk_pkg::TAPER_W-1:0];
			end
			if (out_valid_q && out_ready && state_q != S_ELOAD) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!in_stream_q) begin
							taper_q <= (n_steps_q > plk_pkg::TAPER_W'(MAX_STEPS)) ?
								plk_pkg::TAPER_W'(MAX_STEPS) : n_steps_q;
						end
						in_stream_q <= 1'b1;
						last_q <= last;
						fill_q <= fill_q + 1'b1;
						state_q <= S_EXAM;
					end
				end
				S_EXAM: begin
					if (exam_go) begin
						p_q <= done_q;
						p_addr_q <= ram_raddr;
						done_q <= done_q + 1'b1;
						state_q <= S_EVAL;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EVAL: begin
					if (peak_hi || peak_lo) begin
						mag_q <= rd_mag;
						den_q <= plk_pkg::DEN_W'(rd_mag) * plk_pkg::DEN_W'(n1);
						k_q <= plk_pkg::K_W'(1);
						side_q <= 1'b0;
						state_q <= S_NBSEL;
					end else begin
						state_q <= S_EXAM;
					end
				end
				S_NBSEL: begin
					num_q <= (plk_pkg::NUM_W'(n1) << plk_pkg::FRAC_W) +
						plk_pkg::NUM_W'(k_q) * plk_pkg::NUM_W'(mag_q - plk_pkg::Q_ONE);
					if (k_over) begin
						state_q <= S_EXAM;
					end else if (nb_avail) begin
						nb_addr_q <= ram_raddr;
						state_q <= S_NBMUL;
					end else if (side_q) begin
						side_q <= 1'b0;
						k_q <= k_q + 1'b1;
					end else begin
						side_q <= 1'b1;
					end
				end
				S_NBMUL: begin
					prod_q <= plk_pkg::PROD_W'(rd_mag) * plk_pkg::PROD_W'(num_q);
					neg_q <= rd_s[SW-1];
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						if (side_q) begin
							side_q <= 1'b0;
							k_q <= k_q + 1'b1;
						end else begin
							side_q <= 1'b1;
						end
						state_q <= S_NBSEL;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_ELOAD;
					end else begin
						if (last_q) begin
							in_stream_q <= 1'b0;
							fill_q <= '0;
							done_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_ELOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q <= $signed(ram_rdata);
						out_eos_q <= last_q && (fill_q == CW'(1));
						head_q <= (head_q == AW'(WIN - 1)) ? '0 : head_q + 1'b1;
						fill_q <= fill_q - 1'b1;
						if (done_q != '0) begin
							done_q <= done_q - 1'b1;
						end
						state_q <= S_EMIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sample_out = out_data_q;
	assign end_of_stream = out_eos_q;

	plk_ram #(
		.WIDTH(SW),
		.DEPTH(WIN)
	) u_window (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	plk_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quo)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(WIN))
		else $error("window fill exceeds its size");

	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= fill_q)
		else $error("examined count exceeds window fill");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !in_stream_q) |-> (fill_q == '0))
		else $error("window not empty between streams");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < AW'(WIN))
		else $error("window head pointer out of range");

endmodule

// File: tb/sv/plk_checker.sv
// Checker for the peak limiter with taper: watches the input, output and config channels.
// Predicts the limited, tapered output stream and compares it field by field.
// Depends on plk_pkg.
`timescale 1ns / 100ps
module plk_checker #(
	parameter int MAX_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [plk_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [plk_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                end_of_stream,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [plk_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [plk_pkg::CFG_DATA_W-1:0]      pwdata,
	output int                                  fail_count,
	output int                                  pending_count
);

	localparam int WIN = 2 * MAX_STEPS + 1;

	typedef struct packed {
		logic signed [plk_pkg::SAMPLE_W-1:0] value;
		logic                                eos;
	} out_item_t;

	out_item_t expected_q[$];
	longint held[WIN];
	int held_n, stream_pos, examined, taper, n_steps_reg;

	function automatic longint rescale(longint y, longint num, longint den);
		longint mag, q;
		mag = (y < 0) ? -y : y;
		q = (mag * num * 2 + den) / (2 * den);
		return (y < 0) ? -q : q;
	endfunction

	function automatic void limit_at(int p);
		longint x, mag, n1, den, num;
		x = held[p];
		n1 = taper + 1;
		if (x > 1048576) begin
			mag = x;
			held[p] = 1048576;
		end else if (x < -1048576) begin
			mag = -x;
			held[p] = -1048576;
		end else begin
			return;
		end
		den = mag * n1;
		for (int k = 1; k <= taper; k++) begin
			num = n1 * 1048576 + k * (mag - 1048576);
			if (p + k < held_n)
				held[p + k] = rescale(held[p + k], num, den);
			if (k <= p)
				held[p - k] = rescale(held[p - k], num, den);
		end
	endfunction

	function automatic void emit_oldest(logic eos);
		out_item_t it;
		it.value = held[0][plk_pkg::SAMPLE_W-1:0];
		it.eos = eos;
		expected_q.push_back(it);
		for (int i = 0; i < WIN - 1; i++)
			held[i] = held[i + 1];
		held_n--;
		if (examined > 0)
			examined--;
	endfunction

	function automatic void take_sample(logic signed [plk_pkg::SAMPLE_W-1:0] s,
	                                    logic is_last);
		if (held_n == 0 && stream_pos == 0)
			taper = (n_steps_reg > MAX_STEPS) ? MAX_STEPS : n_steps_reg;
		if (held_n >= WIN)
			emit_oldest(1'b0);
		held[held_n++] = s;
		if (stream_pos < WIN)
			stream_pos++;
		while (examined + taper < held_n)
			limit_at(examined++);
		if (is_last) begin
			while (examined < held_n)
				limit_at(examined++);
			while (held_n > 0)
				emit_oldest(held_n == 1);
			examined = 0;
			stream_pos = 0;
		end else begin
			while (examined > taper && held_n > 0)
				emit_oldest(1'b0);
		end
	endfunction

	assign pending_count = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			expected_q.delete();
			held_n = 0;
			stream_pos = 0;
			examined = 0;
			taper = int'(plk_pkg::N_STEPS_RESET);
			n_steps_reg = int'(plk_pkg::N_STEPS_RESET);
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == plk_pkg::REG_N_STEPS)
				n_steps_reg = int'(pwdata[plk_pkg::TAPER_W-1:0]);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected transaction sample_out=%0d eos=%0b",
						$time, sample_out, end_of_stream);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (want.value !== sample_out) begin
						$display("%0t: sample_out expected %0d actual %0d",
							$time, want.value, sample_out);
						fail_count++;
					end
					if (want.eos !== end_of_stream) begin
						$display("%0t: end_of_stream expected %0b actual %0b",
							$time, want.eos, end_of_stream);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				take_sample(sample, last);
		end
	end
endmodule

// File: tb/sv/testbench.sv
// Testbench top for the peak limiter with taper: clock, reset, stimulus and verdict.
// Depends on plk_pkg, peak_limiter_with_taper and plk_checker.
`timescale 1ns / 100ps
module testbench;

	logic clk, arst_n;
	logic in_valid, in_ready, last, out_valid, out_ready, end_of_stream;
	logic signed [plk_pkg::SAMPLE_W-1:0] sample, sample_out;
	logic psel, penable, pwrite, pready;
	logic [plk_pkg::CFG_ADDR_W-1:0] paddr;
	logic [plk_pkg::CFG_DATA_W-1:0] pwdata, prdata;
	int fail_count, pending_count, cycles;
	logic no_idle, hold_off;

	peak_limiter_with_taper u_top (.*);
	plk_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: random stalls, with one long hold-off to back the block up.
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off)
				out_ready <= 0;
			else
				out_ready <= no_idle || ($urandom_range(99) >= 20);
		end
	end

	task automatic write_taper(int value);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= 0;
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send(logic signed [plk_pkg::SAMPLE_W-1:0] s, logic is_last);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 20) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		sample <= s;
		last <= is_last;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 0;
	endtask

	function automatic logic signed [plk_pkg::SAMPLE_W-1:0] rand_sample();
		unique case ($urandom_range(3))
			0: return plk_pkg::SAMPLE_W'($urandom);
			1: return $signed(24'($urandom_range(2097152))) - 24'sd1048576;
			2: return ($urandom_range(1)) ? plk_pkg::Q_ONE : plk_pkg::Q_MINUS_ONE;
			default: return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
		endcase
	endfunction

	task automatic drain();
		while (pending_count != 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);
	endtask

	task automatic random_stream(int len);
		for (int i = 0; i < len; i++)
			send(rand_sample(), i == len - 1);
	endtask

	initial begin
		int sent;
		arst_n = 0;
		in_valid = 0;
		sample = 0;
		last = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		no_idle = 0;
		hold_off = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send(24'sh7FFFFF, 1);
		send(24'sh800000, 0);
		send(24'sd0, 0);
		send(plk_pkg::Q_ONE + 24'sd1, 0);
		send(plk_pkg::Q_MINUS_ONE, 0);
		send(24'sh555555, 0);
		send(24'shAAAAAA, 1);
		drain();
		write_taper(0);
		send(24'sh7FFFFF, 0);
		send(24'sh123456, 0);
		send(24'sh800000, 1);
		drain();
		write_taper(31);
		for (int i = 0; i < 8; i++)
			send((i % 3 == 0) ? 24'sh7FFFFF : 24'sh0FFFFF, i == 7);
		drain();
		write_taper(16);

		sent = 18;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_off = 1;
				repeat (1500) @(posedge clk);
				hold_off = 0;
			end
		join_none
		random_stream(40);
		sent += 40;
		drain();
		while (sent < 120) begin
			int len;
			len = $urandom_range(1, 14);
			if ($urandom_range(3) == 0) begin
				drain();
				write_taper($urandom_range(31));
			end
			no_idle = (sent > 60 && sent < 80);
			random_stream(len);
			sent += len;
		end
		no_idle = 0;
		drain();
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
